// ----- hw/rtl/slcc_pkg.sv -----
// Shared types and constants for the scheduled lights and cooling controller.
// Depends on nothing; used by the channel interfaces and the top level.
package slcc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_GOAL_TEMPERATURE     = 3'd0,
    REG_TEMPERATURE_MARGIN   = 3'd1,
    REG_LIGHTS_ON_HOUR       = 3'd2,
    REG_LIGHTS_ON_MINUTE     = 3'd3,
    REG_LIGHTS_OFF_HOUR      = 3'd4,
    REG_LIGHTS_OFF_MINUTE    = 3'd5,
    REG_LOG_INTERVAL_MINUTES = 3'd6
  } cfg_reg_t;

  localparam logic signed [15:0] GoalTemperatureRst    = 16'sd2000;
  localparam logic        [14:0] TemperatureMarginRst  = 15'd100;
  localparam logic        [4:0]  LightsOnHourRst       = 5'd8;
  localparam logic        [5:0]  LightsOnMinuteRst     = 6'd20;
  localparam logic        [4:0]  LightsOffHourRst      = 5'd20;
  localparam logic        [5:0]  LightsOffMinuteRst    = 6'd20;
  localparam logic        [9:0]  LogIntervalMinutesRst = 10'd5;

  localparam logic [15:0] SecondsPerMinute = 16'd60;
  localparam logic [15:0] CounterMax       = 16'hFFFF;

  typedef struct packed {
    logic [4:0]         hour_now;
    logic [5:0]         minute_now;
    logic signed [15:0] temperature;
    logic               log_accepted;
  } tick_word_t;

  typedef struct packed {
    logic lights_on;
    logic cooler_on;
    logic log_request;
  } result_word_t;

endpackage

// ----- hw/rtl/slcc_if.sv -----
// Valid/ready channel interfaces: tick input, result output, register writes.
// Depends on slcc_pkg for the word types.
interface slcc_tick_if
  import slcc_pkg::*;
();
  logic       valid;
  logic       ready;
  tick_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slcc_result_if
  import slcc_pkg::*;
();
  logic         valid;
  logic         ready;
  result_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slcc_cfg_if
  import slcc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  addr;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ----- hw/rtl/scheduled_lights_and_cooling_control_top.sv -----
// The result word of a tick word is registered and is presented in the cycle after the tick is accepted.
// Throughput: one tick word per cycle; the only stage is the result register, and a new
// tick is taken whenever that register is empty or is being emptied in the same cycle.
// Reset (rst, synchronous, active high): registers return to their power-on values,
// lights and cooler off, seconds counter zero, result register empty.
// Depends on slcc_pkg and the channel interfaces in slcc_if.sv.
module scheduled_lights_and_cooling_control_top
  import slcc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  slcc_cfg_if.sink      cfg,
  slcc_tick_if.sink     tick,
  slcc_result_if.source result
);

  // Configuration registers
  logic signed [15:0] goal_temperature;
  logic        [14:0] temperature_margin;
  logic        [4:0]  lights_on_hour;
  logic        [5:0]  lights_on_minute;
  logic        [4:0]  lights_off_hour;
  logic        [5:0]  lights_off_minute;
  logic        [9:0]  log_interval_minutes;

  // Controller state
  logic        light_state;
  logic        cooler_state;
  logic [15:0] seconds_counter;

  // Result register
  logic         out_valid;
  result_word_t out_word;

  logic         tick_fire;
  logic         light_next;
  logic         cooler_next;
  logic         request;
  logic [15:0]  seconds_counter_next;

  // Times packed hour-above-minute compare in the same order as hour first, then minute
  logic [10:0]        on_time;
  logic [10:0]        off_time;
  logic [10:0]        now_time;
  logic signed [17:0] temp_ext;
  logic signed [17:0] upper;
  logic signed [17:0] lower;
  logic [15:0]        log_limit;

  // Register writes are always taken; the writer must use the port only while idle (not enforced here).
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_temperature     <= GoalTemperatureRst;
      temperature_margin   <= TemperatureMarginRst;
      lights_on_hour       <= LightsOnHourRst;
      lights_on_minute     <= LightsOnMinuteRst;
      lights_off_hour      <= LightsOffHourRst;
      lights_off_minute    <= LightsOffMinuteRst;
      log_interval_minutes <= LogIntervalMinutesRst;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_GOAL_TEMPERATURE:     goal_temperature     <= $signed(cfg.wdata);
        REG_TEMPERATURE_MARGIN:   temperature_margin   <= cfg.wdata[14:0];
        REG_LIGHTS_ON_HOUR:       lights_on_hour       <= cfg.wdata[4:0];
        REG_LIGHTS_ON_MINUTE:     lights_on_minute     <= cfg.wdata[5:0];
        REG_LIGHTS_OFF_HOUR:      lights_off_hour      <= cfg.wdata[4:0];
        REG_LIGHTS_OFF_MINUTE:    lights_off_minute    <= cfg.wdata[5:0];
        REG_LOG_INTERVAL_MINUTES: log_interval_minutes <= cfg.wdata[9:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Take a new tick whenever the result register is free or being drained.
  assign tick.ready = !out_valid || result.ready;
  assign tick_fire  = tick.valid && tick.ready;

  assign on_time  = {lights_on_hour, lights_on_minute};
  assign off_time = {lights_off_hour, lights_off_minute};
  assign now_time = {tick.data.hour_now, tick.data.minute_now};

  // Light window: overnight when on is later than off, daytime when earlier,
  // hold the current state when the two times coincide.
  always_comb begin
    light_next = light_state;
    if (on_time > off_time) begin
      light_next = (now_time > on_time) || (now_time < off_time);
    end else if (on_time < off_time) begin
      light_next = !((now_time > off_time) || (now_time < on_time));
    end
  end

  // Hysteresis thresholds, widened so that the sums never wrap.
  assign temp_ext = {{2{tick.data.temperature[15]}}, tick.data.temperature};
  assign upper    = {{2{goal_temperature[15]}}, goal_temperature} + $signed({3'b000, temperature_margin});
  assign lower    = {{2{goal_temperature[15]}}, goal_temperature} - $signed({3'b000, temperature_margin});

  // On at or above the upper bound wins over off at or below the lower one.
  always_comb begin
    cooler_next = cooler_state;
    if (temp_ext >= upper) begin
      cooler_next = 1'b1;
    end else if (temp_ext <= lower) begin
      cooler_next = 1'b0;
    end
  end

  // At most 1023 minutes, so the limit fits in 16 bits.
  assign log_limit = {6'b000000, log_interval_minutes} * SecondsPerMinute;
  assign request   = seconds_counter >= log_limit;

  // An accepted record restarts the count at one (cleared, then this tick counted).
  always_comb begin
    if (request && tick.data.log_accepted) begin
      seconds_counter_next = 16'd1;
    end else if (seconds_counter != CounterMax) begin
      seconds_counter_next = seconds_counter + 16'd1;
    end else begin
      seconds_counter_next = seconds_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_state     <= 1'b0;
      cooler_state    <= 1'b0;
      seconds_counter <= '0;
    end else if (tick_fire) begin
      light_state     <= light_next;
      cooler_state    <= cooler_next;
      seconds_counter <= seconds_counter_next;
    end
  end

  // Result register: load on every accepted tick, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_word.lights_on   <= light_next;
      out_word.cooler_on   <= cooler_next;
      out_word.log_request <= request;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_word;

`ifndef ASSERT_OFF
  // Every accepted tick leaves a result waiting in the next cycle.
  a_result_follows_tick: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> out_valid)
    else $error("accepted tick gave no result word");

  // Once a tick has been counted the counter can never read zero.
  a_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> (seconds_counter != 16'd0))
    else $error("seconds counter zero after a tick");

  // With a zero interval every tick raises a log request.
  a_zero_interval_requests: assert property (@(posedge clk) disable iff (rst)
    (tick_fire && (log_interval_minutes == 10'd0)) |=> out_word.log_request)
    else $error("zero interval tick without log request");

  // Published states match the held controller state.
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> ((out_word.lights_on == light_state) && (out_word.cooler_on == cooler_state)))
    else $error("result word disagrees with controller state");
`endif

endmodule
